// ----- rtl/core/mr_pkg.sv -----
// shared types, constants and base table for the miller-rabin prime test
package mr_pkg;

    localparam int NumWidthDef = 48;
    localparam int NumBasesDef = 7;
    localparam int SmallLimit  = 23;
    localparam int KWidth      = 6;
    localparam int IdxWidth    = 3;

    localparam logic [SmallLimit-1:0] SmallPrimeMask = 23'h0A28AC;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SPLIT,
        OP_BASE,
        OP_MUL_RB,
        OP_MUL_BB,
        OP_MUL_RR
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [IdxWidth-1:0] base_idx;
    } t_cmd;

    typedef struct packed {
        logic              lt_limit;
        logic              small_prime;
        logic              m_odd;
        logic              e_zero;
        logic              e_odd;
        logic              r_one;
        logic              r_nm1;
        logic              busy;
        logic [KWidth-1:0] k;
    } t_stat;

    function automatic logic [4:0] base_of(input logic [IdxWidth-1:0] idx);
        logic [4:0] b;
        case (idx)
            3'd0:    b = 5'd2;
            3'd1:    b = 5'd3;
            3'd2:    b = 5'd5;
            3'd3:    b = 5'd7;
            3'd4:    b = 5'd11;
            3'd5:    b = 5'd13;
            3'd6:    b = 5'd17;
            default: b = 5'd2;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/core/mr_datapath.sv -----
// datapath: candidate split, exponent registers and bit-serial multiply-reduce unit
module mr_datapath import mr_pkg::*; #(
    parameter int NUM_WIDTH = NumWidthDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [NUM_WIDTH-1:0] i_candidate,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat
);

    logic [NUM_WIDTH-1:0] r_n, r_m, r_e, r_r, r_b, r_acc, r_x, r_y;
    logic [KWidth-1:0]    r_k;
    logic                 r_busy;
    t_op                  r_dest;

    logic [NUM_WIDTH:0]   w_sum, w_dbl;
    logic [NUM_WIDTH-1:0] w_acc_n, w_x_n, w_nm1;

    assign w_sum   = {1'b0, r_acc} + {1'b0, r_x};
    assign w_dbl   = {1'b0, r_x} + {1'b0, r_x};
    assign w_acc_n = (w_sum >= {1'b0, r_n}) ? NUM_WIDTH'(w_sum - {1'b0, r_n})
                                             : w_sum[NUM_WIDTH-1:0];
    assign w_x_n   = (w_dbl >= {1'b0, r_n}) ? NUM_WIDTH'(w_dbl - {1'b0, r_n})
                                             : w_dbl[NUM_WIDTH-1:0];
    assign w_nm1   = r_n - NUM_WIDTH'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_n <= i_candidate;
                    r_m <= i_candidate - NUM_WIDTH'(1);
                    r_k <= '0;
                end
                OP_SPLIT: begin
                    r_m <= r_m >> 1;
                    r_k <= r_k + KWidth'(1);
                end
                OP_BASE: begin
                    r_b <= NUM_WIDTH'(base_of(i_cmd.base_idx));
                    r_r <= NUM_WIDTH'(1);
                    r_e <= r_m;
                end
                OP_MUL_RB: begin
                    r_x    <= r_r;
                    r_y    <= r_b;
                    r_acc  <= '0;
                    r_busy <= 1'b1;
                    r_dest <= OP_MUL_RB;
                end
                OP_MUL_BB: begin
                    r_x    <= r_b;
                    r_y    <= r_b;
                    r_acc  <= '0;
                    r_busy <= 1'b1;
                    r_dest <= OP_MUL_BB;
                    r_e    <= r_e >> 1;
                end
                OP_MUL_RR: begin
                    r_x    <= r_r;
                    r_y    <= r_r;
                    r_acc  <= '0;
                    r_busy <= 1'b1;
                    r_dest <= OP_MUL_RR;
                end
                default: begin
                    // one multiplier bit per cycle
                    if (r_busy) begin
                        if (r_y == '0) begin
                            r_busy <= 1'b0;
                            if (r_dest == OP_MUL_BB) begin
                                r_b <= r_acc;
                            end else begin
                                r_r <= r_acc;
                            end
                        end else begin
                            if (r_y[0]) begin
                                r_acc <= w_acc_n;
                            end
                            r_x <= w_x_n;
                            r_y <= r_y >> 1;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_stat.lt_limit    = r_n < NUM_WIDTH'(SmallLimit);
        o_stat.small_prime = SmallPrimeMask[r_n[4:0]];
        o_stat.m_odd       = r_m[0];
        o_stat.e_zero      = r_e == '0;
        o_stat.e_odd       = r_e[0];
        o_stat.r_one       = r_r == NUM_WIDTH'(1);
        o_stat.r_nm1       = r_r == w_nm1;
        o_stat.busy        = r_busy;
        o_stat.k           = r_k;
    end

endmodule

// ----- rtl/core/mr_ctrl.sv -----
// controller: sequences the split, the exponentiation and the squaring rounds per base
module mr_ctrl import mr_pkg::*; #(
    parameter int NUM_BASES = NumBasesDef
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_load,
    output logic  o_result
);

    typedef enum logic [3:0] {
        S_IDLE, S_SMALL, S_SPLIT, S_BASE, S_EXP, S_WRB, S_SQB, S_WBB,
        S_CHK, S_SQ, S_WSQ, S_SQC, S_FIN
    } t_state;

    t_state              r_state;
    logic [IdxWidth-1:0] r_idx;
    logic [KWidth-1:0]   r_i;
    logic                r_res;

    localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(NUM_BASES - 1);

    always_comb begin
        o_cmd.op       = OP_NONE;
        o_cmd.base_idx = r_idx;
        case (r_state)
            S_IDLE:  if (i_valid) o_cmd.op = OP_LOAD;
            S_SPLIT: if (!i_stat.m_odd) o_cmd.op = OP_SPLIT;
            S_BASE:  o_cmd.op = OP_BASE;
            S_EXP:   if (!i_stat.e_zero && i_stat.e_odd) o_cmd.op = OP_MUL_RB;
            S_SQB:   o_cmd.op = OP_MUL_BB;
            S_SQ:    if (r_i < i_stat.k) o_cmd.op = OP_MUL_RR;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_load   = (r_state == S_FIN) && i_out_free;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_i     <= '0;
            r_res   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE:  if (i_valid) r_state <= S_SMALL;
                S_SMALL: begin
                    if (i_stat.lt_limit) begin
                        r_res   <= i_stat.small_prime;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    if (i_stat.m_odd) begin
                        r_idx   <= '0;
                        r_state <= S_BASE;
                    end
                end
                S_BASE:  r_state <= S_EXP;
                S_EXP: begin
                    if (i_stat.e_zero) begin
                        r_state <= S_CHK;
                    end else if (i_stat.e_odd) begin
                        r_state <= S_WRB;
                    end else begin
                        r_state <= S_SQB;
                    end
                end
                S_WRB:   if (!i_stat.busy) r_state <= S_SQB;
                S_SQB:   r_state <= S_WBB;
                S_WBB:   if (!i_stat.busy) r_state <= S_EXP;
                S_CHK: begin
                    if (i_stat.r_one || i_stat.r_nm1) begin
                        if (r_idx == LastIdx) begin
                            r_res   <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_idx   <= r_idx + IdxWidth'(1);
                            r_state <= S_BASE;
                        end
                    end else begin
                        r_i     <= KWidth'(1);
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_i < i_stat.k) begin
                        r_i     <= r_i + KWidth'(1);
                        r_state <= S_WSQ;
                    end else begin
                        r_res   <= 1'b0;
                        r_state <= S_FIN;
                    end
                end
                S_WSQ:   if (!i_stat.busy) r_state <= S_SQC;
                S_SQC: begin
                    if (i_stat.r_nm1) begin
                        if (r_idx == LastIdx) begin
                            r_res   <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_idx   <= r_idx + IdxWidth'(1);
                            r_state <= S_BASE;
                        end
                    end else if (i_stat.r_one) begin
                        r_res   <= 1'b0;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_FIN:   if (i_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/miller_rabin_prime_test.sv -----
// top level of the deterministic miller-rabin prime test
//
// input channel: i_valid / o_stall carry one candidate word on i_candidate.
// output channel: o_valid / i_stall carry one word on o_is_prime per candidate.
// one candidate is worked on at a time; o_stall is high from the cycle after
// acceptance until the result is written into the output register.
// candidates of 23 and above run up to NUM_BASES rounds, each made of
// about 2*log2(n) modular multiplies plus up to k-1 squarings, all on the
// single bit-serial multiply-reduce unit; most composites finish far
// sooner than a prime.
// the output register holds a finished word while i_stall is high, and the
// next candidate is taken meanwhile; its result waits until the register
// frees up.
// reset (synchronous, active low) returns the controller to idle and
// empties the output register.
module miller_rabin_prime_test import mr_pkg::*; #(
    parameter int NUM_WIDTH = NumWidthDef,
    parameter int NUM_BASES = NumBasesDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [NUM_WIDTH-1:0] i_candidate,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_is_prime
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_busy, w_load, w_result, w_out_free;
    logic  r_o_valid, r_is_prime;

    assign w_out_free = !r_o_valid || !i_stall;

    mr_ctrl #(.NUM_BASES(NUM_BASES)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_out_free(w_out_free),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_busy    (w_busy),
        .o_load    (w_load),
        .o_result  (w_result)
    );

    mr_datapath #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_candidate(i_candidate),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid  <= 1'b1;
            r_is_prime <= w_result;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_stall    = w_busy;
    assign o_valid    = r_o_valid;
    assign o_is_prime = r_is_prime;

endmodule

// ----- rtl/core/mr_checker.sv -----
// port-level checks for the prime test, bound to the top level
module mr_props (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_is_prime
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_is_prime))
        else $error("result word changed while stalled");

    // one candidate at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after acceptance");

    // a new result only comes out of a busy test
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result word without a candidate in work");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind miller_rabin_prime_test mr_props u_mr_props (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_is_prime(o_is_prime)
);
